>>> rtl/core/kll_pkg.sv
package kll_pkg;

    // Default sizes of the lattice.
    localparam int MAX_SECTIONS_DEF = 64;
    localparam int WAVE_WIDTH_DEF   = 24;

    // Reset value of the section count register.
    localparam logic [5:0] SECTION_COUNT_RESET = 6'd49;

    // Lip reflection coefficient, -0.9997 in Q1.15.
    localparam logic signed [15:0] LIP_COEF = -16'sd32758;

    // Rounding offset for a Q15 product.
    localparam int ROUND_HALF = 16384;

    // Word kinds carried on s_tuser.
    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_AREA   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

endpackage

>>> rtl/core/kll_ram.sv
module kll_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/kelly_lochbaum_lattice_filter.sv
// Kelly-Lochbaum vocal-tract lattice filter, one-multiply scattering form.
// Input words arrive on the s_ stream; s_tuser selects what a word does:
// process one glottal sample, write one tube-section area, or clear the
// stored backward waves. A sample word produces exactly one output word on
// the m_ stream (lip-end wave and a saturation flag); other words produce none.
// The section count register is written through cfg_we / cfg_wdata; the user
// is to write it only while idle, which the block itself does not enforce.
// One word is handled at a time, and s_tready is low while it is in work.
// A sample uses one shared multiplier that serves each junction in turn,
// in a multiply state and then an accumulate state. An area write uses a
// 16-step restoring divider that computes the one or two reflection
// coefficients next to the written section; a clear word is handled in idle.
// Reset (aresetn low, synchronous) empties the output register, sets the
// section count to 49 and marks all areas, coefficients and waves as zero
// through per-entry valid bits, so no clearing sweep follows reset.
// If the receiver stalls, the finished word waits in the output register and
// the next word can be accepted and processed; a second result then waits
// until the first one has been taken.
module kelly_lochbaum_lattice_filter #(
    parameter int MAX_SECTIONS = kll_pkg::MAX_SECTIONS_DEF,
    parameter int WAVE_WIDTH   = kll_pkg::WAVE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from 0 up: sample_in[15:0], section_index[21:16], area_value[37:22],
    // zero padding [39:38].
    input  logic [39:0] s_tdata,
    // Bits from 0 up: mode[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from 0 up: sample_out[15:0].
    output logic [15:0] m_tdata,
    // Bits from 0 up: clipped[0].
    output logic [0:0]  m_tuser
);

    localparam int AW = $clog2(MAX_SECTIONS);
    localparam int NW = AW + 1;
    localparam int W  = WAVE_WIDTH;
    localparam int SW = W + 18;

    // Sequencer states.
    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_A_WR   = 13'b0000000000010,
        ST_A_RD1  = 13'b0000000000100,
        ST_A_RD2  = 13'b0000000001000,
        ST_D_LOAD = 13'b0000000010000,
        ST_D_RUN  = 13'b0000000100000,
        ST_D_WR   = 13'b0000001000000,
        ST_P_RD   = 13'b0000010000000,
        ST_P_MUL  = 13'b0000100000000,
        ST_P_ACC  = 13'b0001000000000,
        ST_L_MUL  = 13'b0010000000000,
        ST_L_ACC  = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [5:0] section_count_reg;

    // Fields of the accepted word.
    logic [AW-1:0]        idx_reg;
    logic                 hi_ok_reg;
    logic [15:0]          area_reg;
    logic [NW-1:0]        n_reg;
    logic [NW-1:0]        sec_reg;

    // Valid bits: an entry that is not valid reads as zero.
    logic [MAX_SECTIONS-1:0] area_vld_reg;
    logic [MAX_SECTIONS-1:0] coef_vld_reg;
    logic [MAX_SECTIONS-1:0] wave_vld_reg;
    logic                    area_rv_reg;
    logic                    coef_rv_reg;
    logic                    wave_rv_reg;

    // Neighbor areas and divider.
    logic [15:0] lo_reg;
    logic [15:0] hi_reg;
    logic        pair_reg;
    logic        ge_reg;
    logic [16:0] sum_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvd_reg;
    logic [15:0] q_reg;
    logic [3:0]  cnt_reg;

    // Lattice datapath.
    logic signed [W-1:0]  f_reg;
    logic signed [W-1:0]  b_reg;
    logic signed [W+16:0] p_reg;
    logic                 clip_reg;

    logic        m_tvalid_reg;
    logic [15:0] m_data_reg;
    logic        m_clip_reg;

    // RAM ports.
    logic          area_we;
    logic [AW-1:0] area_raddr;
    logic [15:0]   area_rdata;
    logic          coef_we;
    logic [AW-1:0] coef_waddr;
    logic [15:0]   coef_wdata;
    logic [15:0]   coef_rdata;
    logic          wave_we;
    logic [NW-1:0] wave_wptr;
    logic [AW-1:0] wave_waddr;
    logic [W-1:0]  wave_wdata;
    logic [W-1:0]  wave_rdata;
    logic [AW-1:0] lat_raddr;

    logic          s_fire;
    logic [1:0]    s_mode;
    logic [5:0]    s_idx;
    logic [NW-1:0] n_clamp;

    assign s_fire = s_tvalid && s_tready;
    assign s_mode = s_tuser;
    assign s_idx  = s_tdata[21:16];
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        if (section_count_reg == 6'd0) begin
            n_clamp = NW'(1);
        end else if (32'(section_count_reg) > MAX_SECTIONS) begin
            n_clamp = NW'(MAX_SECTIONS);
        end else begin
            n_clamp = NW'(section_count_reg);
        end
    end

    // Shared multiplier: k*(f-b) at a junction, LIP_COEF*f at the lip end.
    logic signed [15:0]  kq;
    logic signed [W-1:0] bq;
    logic signed [W:0]   diff;
    logic signed [15:0]  mul_a;
    logic signed [W:0]   mul_b;
    logic signed [W+16:0] mul_p;

    assign kq    = coef_rv_reg ? $signed(coef_rdata) : 16'sd0;
    assign bq    = wave_rv_reg ? $signed(wave_rdata) : '0;
    assign diff  = (W+1)'(f_reg) - (W+1)'(bq);
    assign mul_a = (state_reg == ST_L_MUL) ? kll_pkg::LIP_COEF : kq;
    assign mul_b = (state_reg == ST_L_MUL) ? (W+1)'(f_reg) : diff;
    assign mul_p = mul_a * mul_b;

    // Round to nearest (ties up) and saturate to the wave width.
    logic signed [SW-1:0] acc_f;
    logic signed [SW-1:0] acc_b;
    logic [W+2:0]         rnd_f;
    logic [W+2:0]         rnd_b;
    logic                 ovf_f;
    logic                 ovf_b;
    logic [W-1:0]         sat_f;
    logic [W-1:0]         sat_b;

    assign acc_f = (SW'(f_reg) <<< 15) + SW'(p_reg) + SW'(kll_pkg::ROUND_HALF);
    assign acc_b = (SW'(b_reg) <<< 15) + SW'(p_reg) + SW'(kll_pkg::ROUND_HALF);
    assign rnd_f = acc_f[SW-1:15];
    assign rnd_b = acc_b[SW-1:15];
    assign ovf_f = !((&rnd_f[W+2:W-1]) || !(|rnd_f[W+2:W-1]));
    assign ovf_b = !((&rnd_b[W+2:W-1]) || !(|rnd_b[W+2:W-1]));
    assign sat_f = ovf_f ? {rnd_f[W+2], {(W-1){!rnd_f[W+2]}}} : rnd_f[W-1:0];
    assign sat_b = ovf_b ? {rnd_b[W+2], {(W-1){!rnd_b[W+2]}}} : rnd_b[W-1:0];

    // Output saturation to 16 bits.
    logic        ovf_o;
    logic [15:0] sat_o;

    assign ovf_o = !((&f_reg[W-1:15]) || !(|f_reg[W-1:15]));
    assign sat_o = ovf_o ? {f_reg[W-1], {15{!f_reg[W-1]}}} : f_reg[15:0];

    // Divider operands and step.
    logic [15:0] da0;
    logic [15:0] da1;
    logic [16:0] dsum;
    logic [15:0] dmag;
    logic [31:0] dividend;
    logic [17:0] trial;
    logic        tge;
    logic [15:0] coef_val;

    assign da0      = pair_reg ? area_reg : lo_reg;
    assign da1      = pair_reg ? hi_reg : area_reg;
    assign dsum     = 17'(da0) + 17'(da1);
    assign dmag     = (da0 >= da1) ? (da0 - da1) : (da1 - da0);
    assign dividend = {1'b0, dmag, 15'd0} + 32'(dsum[16:1]);
    assign trial    = {rem_reg, dvd_reg[15]};
    assign tge      = (trial >= {1'b0, sum_reg});

    always_comb begin
        if (sum_reg == 17'd0) begin
            coef_val = 16'd0;
        end else if (ge_reg) begin
            coef_val = q_reg[15] ? 16'h7fff : q_reg;
        end else begin
            coef_val = -q_reg;
        end
    end

    // RAM controls.
    assign area_we    = (state_reg == ST_A_WR);
    assign area_raddr = (state_reg == ST_A_WR) ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
    assign coef_we    = (state_reg == ST_D_WR);
    assign coef_waddr = pair_reg ? (idx_reg + AW'(1)) : idx_reg;
    assign coef_wdata = coef_val;
    assign lat_raddr  = (state_reg == ST_P_RD) ? AW'(1) : (sec_reg[AW-1:0] + AW'(1));
    assign wave_we    = (state_reg == ST_P_ACC) || (state_reg == ST_L_ACC);
    assign wave_wptr  = (state_reg == ST_L_ACC) ? (n_reg - NW'(1)) : (sec_reg - NW'(1));
    assign wave_waddr = wave_wptr[AW-1:0];
    assign wave_wdata = sat_b;

    kll_ram #(.WIDTH(16), .DEPTH(MAX_SECTIONS)) u_area_ram (
        .aclk  (aclk),
        .we    (area_we),
        .waddr (idx_reg),
        .wdata (area_reg),
        .raddr (area_raddr),
        .rdata (area_rdata)
    );

    kll_ram #(.WIDTH(16), .DEPTH(MAX_SECTIONS)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (lat_raddr),
        .rdata (coef_rdata)
    );

    kll_ram #(.WIDTH(W), .DEPTH(MAX_SECTIONS)) u_wave_ram (
        .aclk  (aclk),
        .we    (wave_we),
        .waddr (wave_waddr),
        .wdata (wave_wdata),
        .raddr (lat_raddr),
        .rdata (wave_rdata)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_mode == kll_pkg::MODE_SAMPLE) begin
                        state_next = ST_P_RD;
                    end else if (s_mode == kll_pkg::MODE_AREA &&
                                 32'(s_idx) < MAX_SECTIONS) begin
                        state_next = ST_A_WR;
                    end
                end
            end
            ST_A_WR:  state_next = ST_A_RD1;
            ST_A_RD1: state_next = ST_A_RD2;
            ST_A_RD2: begin
                if (idx_reg != '0 || hi_ok_reg) begin
                    state_next = ST_D_LOAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_D_LOAD: state_next = ST_D_RUN;
            ST_D_RUN: begin
                if (cnt_reg == 4'd15) begin
                    state_next = ST_D_WR;
                end
            end
            ST_D_WR: begin
                if (!pair_reg && hi_ok_reg) begin
                    state_next = ST_D_LOAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_P_RD: begin
                state_next = (n_reg == NW'(1)) ? ST_L_MUL : ST_P_MUL;
            end
            ST_P_MUL: state_next = ST_P_ACC;
            ST_P_ACC: begin
                state_next = (sec_reg + NW'(1) == n_reg) ? ST_L_MUL : ST_P_MUL;
            end
            ST_L_MUL: state_next = ST_L_ACC;
            ST_L_ACC: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            section_count_reg <= kll_pkg::SECTION_COUNT_RESET;
            area_vld_reg      <= '0;
            coef_vld_reg      <= '0;
            wave_vld_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                section_count_reg <= cfg_wdata;
            end
            if (s_fire && s_mode == kll_pkg::MODE_CLEAR) begin
                wave_vld_reg <= '0;
            end else if (wave_we) begin
                wave_vld_reg[wave_waddr] <= 1'b1;
            end
            if (area_we) begin
                area_vld_reg[idx_reg] <= 1'b1;
            end
            if (coef_we) begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
            if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        area_rv_reg <= area_vld_reg[area_raddr];
        coef_rv_reg <= coef_vld_reg[lat_raddr];
        wave_rv_reg <= wave_vld_reg[lat_raddr];

        if (s_fire) begin
            idx_reg   <= AW'(s_idx);
            hi_ok_reg <= (32'(s_idx) + 1 < MAX_SECTIONS);
            area_reg  <= s_tdata[37:22];
            n_reg     <= n_clamp;
            sec_reg   <= NW'(1);
            f_reg     <= W'($signed(s_tdata[15:0]));
            clip_reg  <= 1'b0;
        end

        case (state_reg)
            ST_A_RD1: begin
                lo_reg <= area_rv_reg ? area_rdata : 16'd0;
            end
            ST_A_RD2: begin
                hi_reg   <= area_rv_reg ? area_rdata : 16'd0;
                pair_reg <= (idx_reg == '0);
            end
            ST_D_LOAD: begin
                ge_reg  <= (da0 >= da1);
                sum_reg <= dsum;
                rem_reg <= 17'(dividend[31:16]);
                dvd_reg <= dividend[15:0];
                cnt_reg <= 4'd0;
            end
            ST_D_RUN: begin
                rem_reg <= tge ? 17'(trial - {1'b0, sum_reg}) : trial[16:0];
                dvd_reg <= {dvd_reg[14:0], 1'b0};
                q_reg   <= {q_reg[14:0], tge};
                cnt_reg <= cnt_reg + 4'd1;
            end
            ST_D_WR: begin
                pair_reg <= 1'b1;
            end
            ST_P_MUL: begin
                p_reg <= mul_p;
                b_reg <= bq;
            end
            ST_P_ACC: begin
                f_reg    <= sat_f;
                clip_reg <= clip_reg | ovf_f | ovf_b;
                sec_reg  <= sec_reg + NW'(1);
            end
            ST_L_MUL: begin
                p_reg <= mul_p;
                b_reg <= '0;
            end
            ST_L_ACC: begin
                clip_reg <= clip_reg | ovf_b;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_data_reg <= sat_o;
                    m_clip_reg <= clip_reg | ovf_o;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_clip_reg;

`ifndef NO_ASSERTIONS
    // The junction counter never runs past the section count during a pass.
    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_P_MUL || state_reg == ST_P_ACC) |-> (sec_reg < n_reg))
        else $error("junction index out of range");

    // The divider remainder stays below a nonzero divisor.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_D_RUN && sum_reg != 17'd0) |->
            ({1'b0, rem_reg} < {1'b0, sum_reg}))
        else $error("divider remainder not below divisor");

    // An accepted sample word always starts a lattice pass.
    a_pass_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_mode == kll_pkg::MODE_SAMPLE) |=> (state_reg == ST_P_RD))
        else $error("sample word did not start a pass");

    // No wave, coefficient or area is written while the block is idle.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!wave_we && !coef_we && !area_we))
        else $error("memory write while idle");
`endif

endmodule
